// ===== design/smpq_pkg.sv =====
// Shared types and codes for the sorted minimum priority queue.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

    // Operation codes carried in the op field of an input word.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes returned with every result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Input word: one command.
    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } t_in_word;

    // Result word: one per command.
    typedef struct packed {
        logic signed [31:0] min_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_out_word;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/smpq_cell.sv =====
// One storage cell of the sorted chain: holds a key and its valid flag.
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell
    import smpq_pkg::*;
#(
    parameter int KW = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  wire signed [KW-1:0]  i_key,
    input  wire                  i_left_gt,
    input  wire signed [KW-1:0]  i_left_entry,
    input  wire                  i_left_valid,
    input  wire signed [KW-1:0]  i_right_entry,
    input  wire                  i_right_valid,
    output logic signed [KW-1:0] o_entry,
    output logic                 o_valid,
    output logic                 o_gt
);

    logic signed [KW-1:0] r_entry, n_entry;
    logic                 r_valid, n_valid;

    // The new key belongs behind this cell when it is strictly greater.
    assign o_gt    = r_valid && (i_key > r_entry);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (o_gt) begin
                n_entry = r_entry;
                n_valid = r_valid;
            end else if (i_left_gt) begin
                n_entry = i_key;
                n_valid = 1'b1;
            end else begin
                n_entry = i_left_entry;
                n_valid = i_left_valid;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/sorted_min_priority_queue_core.sv =====
// Top level of the sorted minimum priority queue built from a chain of cells.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Signals                  Direction  Transfer
// command    start, i_word, busy      in         start high and busy low at a clock edge
// result     o_done, o_word           out        o_done high for one cycle, always taken
//
// A command is taken every cycle; busy is never raised. Its result word is
// shown in the cycle after the accepting edge. Every cell of the chain decides
// its next contents in the same cycle from its own compare and its neighbors,
// so an insert or remove never walks the chain, whatever the occupancy.
// Reset clears every valid flag and the entry count; stored keys are left as
// they are and are never read until written. The receiver cannot stall.

module sorted_min_priority_queue_core
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_word
);

    // Stored key width: the low bits of the value field, never more than 32.
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int CW = $clog2(CAPACITY + 1);

    // The chain keeps pace with any command stream, so no back-pressure.
    assign busy = 1'b0;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic signed [KW-1:0] w_key;
    t_cell_ctl            w_ctl;

    logic signed [KW-1:0] w_entry [CAPACITY];
    logic                 w_valid [CAPACITY];
    logic                 w_gt    [CAPACITY];

    logic [CW-1:0] r_count, n_count;
    logic          r_done;
    t_out_word     r_word, n_word;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_key    = $signed(i_word.value[KW-1:0]);

    // A rejected command leaves the chain untouched.
    assign w_ctl.ins = w_accept && (i_word.op == OP_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_word.op == OP_REMOVE) && !w_empty;

    // Each cell sees the cell ahead of it (lower keys) on its left and the
    // cell behind it on its right. The head has nothing ahead of it, so it
    // acts as if the key were greater than everything to its left: a key that
    // is not greater than the head lands at the head. The tail pulls in an
    // empty slot on a remove.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 w_lgt;
            logic signed [KW-1:0] w_lentry;
            logic                 w_lvalid;
            logic signed [KW-1:0] w_rentry;
            logic                 w_rvalid;

            if (g == 0) begin : g_head
                assign w_lgt    = 1'b1;
                assign w_lentry = '0;
                assign w_lvalid = 1'b0;
            end else begin : g_body
                assign w_lgt    = w_gt[g-1];
                assign w_lentry = w_entry[g-1];
                assign w_lvalid = w_valid[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_rentry = '0;
                assign w_rvalid = 1'b0;
            end else begin : g_next
                assign w_rentry = w_entry[g+1];
                assign w_rvalid = w_valid[g+1];
            end

            smpq_cell #(
                .KW (KW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_key         (w_key),
                .i_left_gt     (w_lgt),
                .i_left_entry  (w_lentry),
                .i_left_valid  (w_lvalid),
                .i_right_entry (w_rentry),
                .i_right_valid (w_rvalid),
                .o_entry       (w_entry[g]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g])
            );
        end
    endgenerate

    // Count update and the result word for the command being taken.
    always_comb begin
        n_count          = r_count;
        n_word.min_value = '0;
        n_word.status    = ST_OK;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.rem) begin
            n_count          = r_count - 1'b1;
            // The head always holds the minimum; sign-extend it to the field.
            n_word.min_value = 32'(w_entry[0]);
        end else if (i_word.op == OP_INSERT) begin
            n_word.status = ST_FULL;
        end else begin
            n_word.status = ST_EMPTY;
        end
        n_word.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= n_word;
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_done <= w_accept;
        end
    end

    assign o_done = r_done;
    assign o_word = r_word;

endmodule

`default_nettype wire
